// File: design/ihq_pkg.sv
// Shared types, codes and defaults of the indexed min-heap queue.
package ihq_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int KEY_BITS_DEF  = 32;
    localparam int ID_W          = 10;
    localparam int CNT_W         = 11;
    localparam int KEY_W         = 32;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

    localparam logic [1:0] MODE_OFFER    = 2'd0;
    localparam logic [1:0] MODE_POP      = 2'd1;
    localparam logic [1:0] MODE_CONTAINS = 2'd2;

    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;

    localparam int CMD_W = 4;
    localparam logic [CMD_W-1:0] CMD_NOP       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ACCEPT    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_POS_CHECK = 4'd3;
    localparam logic [CMD_W-1:0] CMD_KEY_CHECK = 4'd4;
    localparam logic [CMD_W-1:0] CMD_UP_READ   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_UP_STEP   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_POP_TAKE  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_POP_LAST  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_DN_LEFT   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_DN_PICK_L = 4'd10;
    localparam logic [CMD_W-1:0] CMD_DN_PICK_R = 4'd11;
    localparam logic [CMD_W-1:0] CMD_DN_STEP   = 4'd12;
    localparam logic [CMD_W-1:0] CMD_FINISH    = 4'd13;

    typedef struct packed {
        logic [1:0]              mode;
        logic [ID_W-1:0]         node_index;
        logic signed [KEY_W-1:0] key_value;
    } in_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [ID_W-1:0]         popped_node;
        logic signed [KEY_W-1:0] popped_key;
        logic                    found;
        logic [CNT_W-1:0]        heap_size;
        logic                    is_empty;
    } out_t;

    typedef struct packed {
        logic       clear_last;
        logic       in_valid;
        logic [1:0] in_mode;
        logic       in_reject;
        logic       in_empty;
        logic [1:0] req_mode;
        logic       present;
        logic       slot_ok;
        logic       full;
        logic       key_lower;
        logic       at_root;
        logic       up_move;
        logic       more;
        logic       has_left;
        logic       has_right;
        logic       dn_move;
        logic       out_free;
    } status_t;

endpackage

// File: design/ihq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ihq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/ihq_ctrl.sv
// Controller state machine of the indexed min-heap queue.
module ihq_ctrl
    import ihq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  status_t          st,
    output logic [CMD_W-1:0] cmd,
    output logic             in_stall
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_POS   = 4'd2;
    localparam logic [3:0] S_KEY   = 4'd3;
    localparam logic [3:0] S_UPR   = 4'd4;
    localparam logic [3:0] S_UPD   = 4'd5;
    localparam logic [3:0] S_POPR  = 4'd6;
    localparam logic [3:0] S_POPL  = 4'd7;
    localparam logic [3:0] S_DNL   = 4'd8;
    localparam logic [3:0] S_DNLD  = 4'd9;
    localparam logic [3:0] S_DNRD  = 4'd10;
    localparam logic [3:0] S_DNDEC = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NOP;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd = CMD_CLEAR;
                if (st.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (st.in_valid)
                begin
                    cmd = CMD_ACCEPT;
                    case (st.in_mode) inside
                        MODE_OFFER, MODE_CONTAINS:
                            state_next = st.in_reject ? S_FIN : S_POS;
                        MODE_POP:
                            state_next = st.in_empty ? S_FIN : S_POPR;
                        default:
                            state_next = S_FIN;
                    endcase
                end
            end
            S_POS:
            begin
                cmd = CMD_POS_CHECK;
                if (st.req_mode == MODE_CONTAINS)
                begin
                    state_next = S_FIN;
                end
                else if (st.present)
                begin
                    state_next = st.slot_ok ? S_KEY : S_FIN;
                end
                else
                begin
                    state_next = st.full ? S_FIN : S_UPR;
                end
            end
            S_KEY:
            begin
                cmd        = CMD_KEY_CHECK;
                state_next = st.key_lower ? S_UPR : S_FIN;
            end
            S_UPR:
            begin
                cmd        = CMD_UP_READ;
                state_next = st.at_root ? S_FIN : S_UPD;
            end
            S_UPD:
            begin
                cmd        = CMD_UP_STEP;
                state_next = st.up_move ? S_UPR : S_FIN;
            end
            S_POPR:
            begin
                cmd        = CMD_POP_TAKE;
                state_next = st.more ? S_POPL : S_FIN;
            end
            S_POPL:
            begin
                cmd        = CMD_POP_LAST;
                state_next = S_DNL;
            end
            S_DNL:
            begin
                cmd        = CMD_DN_LEFT;
                state_next = st.has_left ? S_DNLD : S_FIN;
            end
            S_DNLD:
            begin
                cmd        = CMD_DN_PICK_L;
                state_next = st.has_right ? S_DNRD : S_DNDEC;
            end
            S_DNRD:
            begin
                cmd        = CMD_DN_PICK_R;
                state_next = S_DNDEC;
            end
            S_DNDEC:
            begin
                cmd        = CMD_DN_STEP;
                state_next = st.dn_move ? S_DNL : S_FIN;
            end
            S_FIN:
            begin
                cmd = CMD_FINISH;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// File: design/ihq_datapath.sv
// Datapath of the indexed min-heap queue: heap and position memories, working registers.
module ihq_datapath
    import ihq_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int KEY_BITS  = KEY_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CMD_W-1:0] cmd,
    output status_t          st,
    input  logic             in_valid,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int SW   = $clog2(MAX_NODES);
    localparam int HW   = ID_W + KEY_BITS;
    localparam int PW   = CNT_W + 1;
    localparam int MAXW = $clog2(MAX_NODES + 1);
    localparam int CW   = (MAXW > CNT_W) ? MAXW : CNT_W;
    localparam logic [CW-1:0] MAX_CAP = CW'(MAX_NODES);
    localparam logic [SW-1:0] LAST_ADDR = SW'(MAX_NODES - 1);

    logic [CNT_W-1:0] node_count_reg, node_count_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SW-1:0]    clr_addr_reg, clr_addr_next;
    logic             out_valid_reg, out_valid_next;
    out_t             out_reg, out_next;
    in_t              req_reg, req_next;
    logic [1:0]       stat_reg, stat_next;
    logic             found_reg, found_next;
    logic [ID_W-1:0]  pnode_reg, pnode_next;
    logic [KEY_W-1:0] pkey_reg, pkey_next;
    logic [ID_W-1:0]  cur_id_reg, cur_id_next;
    logic signed [KEY_BITS-1:0] cur_key_reg, cur_key_next;
    logic [CNT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] best_slot_reg, best_slot_next;
    logic [ID_W-1:0]  best_id_reg, best_id_next;
    logic signed [KEY_BITS-1:0] best_key_reg, best_key_next;

    logic          heap_we, heap_re;
    logic [SW-1:0] heap_waddr, heap_raddr;
    logic [HW-1:0] heap_wdata, heap_rdata;
    logic          pos_we, pos_re;
    logic [SW-1:0] pos_waddr, pos_raddr;
    logic [PW-1:0] pos_wdata, pos_rdata;

    logic [CW-1:0]              cap;
    logic [KEY_BITS+KEY_W-1:0]  key_wide;
    logic [KEY_BITS+KEY_W-1:0]  out_wide;
    logic signed [KEY_BITS-1:0] req_key;
    logic [ID_W-1:0]            rd_id;
    logic signed [KEY_BITS-1:0] rd_key;
    logic                       pos_present;
    logic [CNT_W-1:0]           pos_slot;
    logic [CNT_W-1:0]           parent;
    logic [CNT_W:0]             left_c, right_c;

    ihq_ram #(.WIDTH(HW), .DEPTH(MAX_NODES)) u_heap_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .re    (heap_re),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    ihq_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            count_reg      <= '0;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            count_reg      <= count_next;
            clr_addr_reg   <= clr_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        req_reg       <= req_next;
        stat_reg      <= stat_next;
        found_reg     <= found_next;
        pnode_reg     <= pnode_next;
        pkey_reg      <= pkey_next;
        cur_id_reg    <= cur_id_next;
        cur_key_reg   <= cur_key_next;
        slot_reg      <= slot_next;
        best_slot_reg <= best_slot_next;
        best_id_reg   <= best_id_next;
        best_key_reg  <= best_key_next;
    end

    assign cap      = (CW'(node_count_reg) > MAX_CAP) ? MAX_CAP : CW'(node_count_reg);
    assign key_wide = {{KEY_BITS{1'b0}}, req_reg.key_value};
    assign req_key  = key_wide[KEY_BITS-1:0];
    assign rd_id    = heap_rdata[HW-1 -: ID_W];
    assign rd_key   = heap_rdata[KEY_BITS-1:0];
    assign out_wide = {{KEY_W{1'b0}}, rd_key};
    assign pos_present = pos_rdata[PW-1];
    assign pos_slot    = pos_rdata[CNT_W-1:0];
    assign parent      = (slot_reg - 1'b1) >> 1;
    assign left_c      = {slot_reg, 1'b1};
    assign right_c     = left_c + 1'b1;

    assign st.clear_last = (clr_addr_reg == LAST_ADDR);
    assign st.in_valid   = in_valid;
    assign st.in_mode    = in_data.mode;
    assign st.in_reject  = (CW'(in_data.node_index) >= cap);
    assign st.in_empty   = (count_reg == '0);
    assign st.req_mode   = req_reg.mode;
    assign st.present    = pos_present;
    assign st.slot_ok    = (pos_slot < count_reg);
    assign st.full       = (CW'(count_reg) >= cap);
    assign st.key_lower  = (req_key < rd_key);
    assign st.at_root    = (slot_reg == '0);
    assign st.up_move    = (cur_key_reg < rd_key);
    assign st.more       = (count_reg > CNT_W'(1));
    assign st.has_left   = (left_c < {1'b0, count_reg});
    assign st.has_right  = (right_c < {1'b0, count_reg});
    assign st.dn_move    = (best_slot_reg != slot_reg);
    assign st.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        node_count_next = node_count_reg;
        count_next      = count_reg;
        clr_addr_next   = clr_addr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;
        req_next        = req_reg;
        stat_next       = stat_reg;
        found_next      = found_reg;
        pnode_next      = pnode_reg;
        pkey_next       = pkey_reg;
        cur_id_next     = cur_id_reg;
        cur_key_next    = cur_key_reg;
        slot_next       = slot_reg;
        best_slot_next  = best_slot_reg;
        best_id_next    = best_id_reg;
        best_key_next   = best_key_reg;
        heap_we    = 1'b0;
        heap_waddr = SW'(slot_reg);
        heap_wdata = {cur_id_reg, cur_key_reg};
        heap_re    = 1'b0;
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = SW'(cur_id_reg);
        pos_wdata  = {1'b1, slot_reg};
        pos_re     = 1'b0;
        pos_raddr  = SW'(in_data.node_index);

        if (cfg_valid && cfg_ready)
        begin
            node_count_next = cfg_data;
        end

        case (cmd)
            CMD_CLEAR:
            begin
                pos_we        = 1'b1;
                pos_waddr     = clr_addr_reg;
                pos_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            CMD_ACCEPT:
            begin
                req_next   = in_data;
                pos_re     = 1'b1;
                heap_re    = 1'b1;
                found_next = 1'b0;
                pnode_next = '0;
                pkey_next  = '0;
                stat_next  = STAT_DONE;
                case (in_data.mode) inside
                    MODE_OFFER, MODE_CONTAINS:
                        if (st.in_reject)
                        begin
                            stat_next = STAT_REJECT;
                        end
                    MODE_POP:
                        if (st.in_empty)
                        begin
                            stat_next = STAT_EMPTY;
                        end
                    default:
                        stat_next = STAT_DONE;
                endcase
            end
            CMD_POS_CHECK:
            begin
                if (req_reg.mode == MODE_CONTAINS)
                begin
                    found_next = pos_present;
                end
                else if (pos_present)
                begin
                    slot_next  = pos_slot;
                    heap_re    = 1'b1;
                    heap_raddr = SW'(pos_slot);
                end
                else if (st.full)
                begin
                    stat_next = STAT_REJECT;
                end
                else
                begin
                    cur_id_next  = req_reg.node_index;
                    cur_key_next = req_key;
                    slot_next    = count_reg;
                    count_next   = count_reg + 1'b1;
                end
            end
            CMD_KEY_CHECK:
            begin
                if (st.key_lower)
                begin
                    found_next   = 1'b1;
                    cur_id_next  = req_reg.node_index;
                    cur_key_next = req_key;
                end
            end
            CMD_UP_READ:
            begin
                if (st.at_root)
                begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                end
                else
                begin
                    heap_re    = 1'b1;
                    heap_raddr = SW'(parent);
                end
            end
            CMD_UP_STEP:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (st.up_move)
                begin
                    heap_wdata = heap_rdata;
                    pos_waddr  = SW'(rd_id);
                    slot_next  = parent;
                end
            end
            CMD_POP_TAKE:
            begin
                pnode_next = rd_id;
                pkey_next  = out_wide[KEY_W-1:0];
                pos_we     = 1'b1;
                pos_waddr  = SW'(rd_id);
                pos_wdata  = '0;
                count_next = count_reg - 1'b1;
                heap_re    = 1'b1;
                heap_raddr = SW'(count_reg - 1'b1);
            end
            CMD_POP_LAST:
            begin
                cur_id_next  = rd_id;
                cur_key_next = rd_key;
                slot_next    = '0;
            end
            CMD_DN_LEFT:
            begin
                best_slot_next = slot_reg;
                best_id_next   = cur_id_reg;
                best_key_next  = cur_key_reg;
                if (st.has_left)
                begin
                    heap_re    = 1'b1;
                    heap_raddr = SW'(left_c);
                end
                else
                begin
                    heap_we = 1'b1;
                    pos_we  = 1'b1;
                end
            end
            CMD_DN_PICK_L:
            begin
                if (rd_key < cur_key_reg)
                begin
                    best_slot_next = left_c[CNT_W-1:0];
                    best_id_next   = rd_id;
                    best_key_next  = rd_key;
                end
                if (st.has_right)
                begin
                    heap_re    = 1'b1;
                    heap_raddr = SW'(right_c);
                end
            end
            CMD_DN_PICK_R:
            begin
                if (rd_key < best_key_reg)
                begin
                    best_slot_next = right_c[CNT_W-1:0];
                    best_id_next   = rd_id;
                    best_key_next  = rd_key;
                end
            end
            CMD_DN_STEP:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (st.dn_move)
                begin
                    heap_wdata = {best_id_reg, best_key_reg};
                    pos_waddr  = SW'(best_id_reg);
                    slot_next  = best_slot_reg;
                end
            end
            CMD_FINISH:
            begin
                if (st.out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = stat_reg;
                    out_next.popped_node = pnode_reg;
                    out_next.popped_key  = pkey_reg;
                    out_next.found       = found_reg;
                    out_next.heap_size   = count_reg;
                    out_next.is_empty    = (count_reg == '0);
                end
            end
            default:
            begin
                clr_addr_next = clr_addr_reg;
            end
        endcase
    end

endmodule

// File: design/indexed_min_heap_queue.sv
// Indexed min-heap priority queue with decrease-key, position map and pop-minimum.
//
// Input requests arrive on in_valid/in_stall/in_data: offer (insert or lower a
// key), pop minimum, or contains query. One result comes back for each request
// on out_valid/out_stall/out_data, in order. node_count is written on
// cfg_valid/cfg_ready/cfg_data; cfg_ready is always high. The user must write
// it only while the queue is idle; the block itself does not enforce this.
// Requests are handled one at a time. Rejected, empty-pop and unknown-mode
// requests go straight from acceptance to the finish state; a contains query
// reads the position map. An insert climbs the heap from the new last slot, a
// key decrease first reads the entry's slot and key, and a pop takes the root
// and, unless it removed the last entry, moves the last entry there and sinks
// it. Each level of the sift loop costs a registered read of the heap memory, a
// key compare and one write. After reset the position map is cleared, one entry
// a cycle, and in_stall stays high until it finishes.
// A finished result waits in the output register while out_stall is high; the
// next request is accepted meanwhile, and its result holds until the
// register frees.
module indexed_min_heap_queue
    import ihq_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int KEY_BITS  = KEY_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    logic [CMD_W-1:0] cmd;
    status_t          st;

    assign cfg_ready = 1'b1;

    ihq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .st       (st),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    ihq_datapath #(.MAX_NODES(MAX_NODES), .KEY_BITS(KEY_BITS)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("queue took a request without going busy");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.heap_size <= MAX_NODES))
        else $error("heap size beyond capacity");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == STAT_EMPTY) |->
            (out_data.is_empty && out_data.popped_node == '0))
        else $error("empty pop reported a node");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.found) |-> (out_data.status == STAT_DONE))
        else $error("found set on a failed request");
`endif

endmodule

// File: test/tb.sv
// Testbench for the indexed min-heap queue: directed and random requests checked against a behavioral heap model.
`timescale 1ns / 1ps

module tb;
    import ihq_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_t              in_data;
    logic             out_valid;
    logic             out_stall;
    out_t             out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    indexed_min_heap_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    logic [ID_W-1:0]         heap_id  [MAX_NODES_DEF];
    logic signed [KEY_W-1:0] heap_key [MAX_NODES_DEF];
    int                      slot_of  [MAX_NODES_DEF];
    bit                      queued   [MAX_NODES_DEF];
    int                      entries;
    int                      node_limit;

    out_t results_pending[$];
    int   errors;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_recv;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("[indexed_min_heap_queue] ERROR");
        $finish;
    end

    function automatic void swap_slots(int a, int b);
        logic [ID_W-1:0]         t_id;
        logic signed [KEY_W-1:0] t_key;
        t_id = heap_id[a];
        t_key = heap_key[a];
        heap_id[a] = heap_id[b];
        heap_key[a] = heap_key[b];
        heap_id[b] = t_id;
        heap_key[b] = t_key;
        slot_of[heap_id[a]] = a;
        slot_of[heap_id[b]] = b;
    endfunction

    function automatic void sift_up(int s);
        int p;
        while (s > 0)
        begin
            p = (s - 1) / 2;
            if (heap_key[s] >= heap_key[p])
                break;
            swap_slots(s, p);
            s = p;
        end
    endfunction

    function automatic void sift_down(int s);
        int l;
        int r;
        int best;
        forever
        begin
            l = 2 * s + 1;
            r = 2 * s + 2;
            best = s;
            if (l < entries && heap_key[l] < heap_key[best])
                best = l;
            if (r < entries && heap_key[r] < heap_key[best])
                best = r;
            if (best == s)
                break;
            swap_slots(s, best);
            s = best;
        end
    endfunction

    function automatic out_t heap_apply(in_t req);
        out_t res;
        int   cap;
        int   s;
        res = '0;
        cap = (node_limit > MAX_NODES_DEF) ? MAX_NODES_DEF : node_limit;
        if (req.mode == MODE_OFFER || req.mode == MODE_CONTAINS)
        begin
            if (int'(req.node_index) >= cap)
                res.status = STAT_REJECT;
            else if (req.mode == MODE_CONTAINS)
                res.found = queued[req.node_index];
            else if (queued[req.node_index])
            begin
                s = slot_of[req.node_index];
                if (s < entries && req.key_value < heap_key[s])
                begin
                    heap_key[s] = req.key_value;
                    sift_up(s);
                    res.found = 1'b1;
                end
            end
            else if (entries >= cap)
                res.status = STAT_REJECT;
            else
            begin
                s = entries;
                heap_id[s] = req.node_index;
                heap_key[s] = req.key_value;
                slot_of[req.node_index] = s;
                queued[req.node_index] = 1'b1;
                entries++;
                sift_up(s);
            end
        end
        else if (req.mode == MODE_POP)
        begin
            if (entries == 0)
                res.status = STAT_EMPTY;
            else
            begin
                res.popped_node = heap_id[0];
                res.popped_key = heap_key[0];
                queued[heap_id[0]] = 1'b0;
                entries--;
                if (entries > 0)
                begin
                    heap_id[0] = heap_id[entries];
                    heap_key[0] = heap_key[entries];
                    slot_of[heap_id[0]] = 0;
                    sift_down(0);
                end
            end
        end
        res.heap_size = CNT_W'(entries);
        res.is_empty = (entries == 0);
        return res;
    endfunction

    task automatic send_request(logic [1:0] mode, logic [ID_W-1:0] id,
                                logic signed [KEY_W-1:0] key);
        in_t req;
        req.mode = mode;
        req.node_index = id;
        req.key_value = key;
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        in_data = req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        results_pending.push_back(heap_apply(req));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain;
        while (results_pending.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_node_limit(logic [CNT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        node_limit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
        out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_pending.size() == 0)
            begin
                $error("result with nothing pending");
                errors++;
            end
            else
            begin
                want = results_pending.pop_front();
                if (out_data.status !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, out_data.status);
                    errors++;
                end
                if (out_data.popped_node !== want.popped_node)
                begin
                    $error("popped_node exp %0d got %0d", want.popped_node,
                           out_data.popped_node);
                    errors++;
                end
                if (out_data.popped_key !== want.popped_key)
                begin
                    $error("popped_key exp %0d got %0d", want.popped_key,
                           out_data.popped_key);
                    errors++;
                end
                if (out_data.found !== want.found)
                begin
                    $error("found exp %0d got %0d", want.found, out_data.found);
                    errors++;
                end
                if (out_data.heap_size !== want.heap_size)
                begin
                    $error("heap_size exp %0d got %0d", want.heap_size,
                           out_data.heap_size);
                    errors++;
                end
                if (out_data.is_empty !== want.is_empty)
                begin
                    $error("is_empty exp %0d got %0d", want.is_empty, out_data.is_empty);
                    errors++;
                end
            end
        end
    end

    task automatic random_ops(int n, int id_span);
        int r;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 50)
                send_request(MODE_OFFER, ID_W'($urandom_range(id_span)), $urandom);
            else if (r < 85)
                send_request(MODE_POP, ID_W'($urandom), $urandom);
            else if (r < 97)
                send_request(MODE_CONTAINS, ID_W'($urandom_range(id_span)), $urandom);
            else
                send_request(2'd3, ID_W'($urandom), $urandom);
        end
    endtask

    task automatic test_directed;
        send_request(MODE_POP, '0, '0);
        send_request(MODE_OFFER, 10'd5, 32'sd100);
        send_request(MODE_OFFER, 10'd1023, 32'h8000_0000);
        send_request(MODE_OFFER, 10'd0, 32'h7FFF_FFFF);
        send_request(MODE_OFFER, 10'd7, 32'sd100);
        send_request(MODE_OFFER, 10'd5, 32'sd200);
        send_request(MODE_OFFER, 10'd5, 32'sd100);
        send_request(MODE_OFFER, 10'd0, -32'sd5);
        send_request(MODE_CONTAINS, 10'd0, '0);
        send_request(MODE_CONTAINS, 10'd9, '0);
        send_request(2'd3, 10'h3FF, 32'hFFFF_FFFF);
        repeat (6) send_request(MODE_POP, 10'h3FF, '1);
        write_node_limit(11'd2);
        send_request(MODE_OFFER, 10'd2, 32'sd1);
        send_request(MODE_CONTAINS, 10'd2, 32'sd1);
        send_request(MODE_OFFER, 10'd0, 32'sd3);
        send_request(MODE_OFFER, 10'd1, 32'sd3);
        send_request(MODE_OFFER, 10'd1, 32'sd2);
        write_node_limit(11'd0);
        send_request(MODE_OFFER, 10'd0, 32'sd1);
        send_request(MODE_POP, '0, '0);
        send_request(MODE_POP, '0, '0);
        send_request(MODE_POP, '0, '0);
    endtask

    task automatic test_random_phases;
        write_node_limit(11'd1024);
        send_idle_pct = 0;  recv_stall_pct = 0;  random_ops(400, 1023);
        write_node_limit(11'd16);
        send_idle_pct = 82; recv_stall_pct = 0;  random_ops(300, 31);
        write_node_limit(11'd1);
        send_idle_pct = 0;  recv_stall_pct = 82; random_ops(100, 3);
        write_node_limit(11'd2047);
        send_idle_pct = 17; recv_stall_pct = 17; random_ops(400, 1023);
        write_node_limit(11'd64);
        random_ops(364, 80);
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_recv = 1'b1;
                repeat (300) @(negedge clk);
                hold_recv = 1'b0;
            end
            random_ops(40, 70);
        join
        drain();
        random_ops(20, 70);
    endtask

    initial
    begin
        errors = 0;
        entries = 0;
        node_limit = NODE_COUNT_RST;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b0;
        foreach (queued[i])
        begin
            queued[i] = 1'b0;
            slot_of[i] = 0;
        end
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_phases();
        test_backpressure();
        drain();
        if (errors == 0)
            $display("[indexed_min_heap_queue] OK");
        else
            $display("[indexed_min_heap_queue] ERROR");
        $finish;
    end
endmodule
